/* rtl/sdll_pkg.sv */
`timescale 1ns / 1ps

package sdll_pkg;

    // Store geometry
    localparam int NODES  = 64;
    localparam int SLOT_W = 6;
    localparam int VAL_W  = 32;

    localparam logic [SLOT_W-1:0] HEAD = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] TAIL = SLOT_W'(1);
    localparam logic [SLOT_W:0]   FIRST_FREE = (SLOT_W+1)'(2);

    // Operation and status codes
    typedef enum logic [1:0] {
        OP_INS_AFTER  = 2'd0,
        OP_INS_BEFORE = 2'd1,
        OP_DELETE     = 2'd2,
        OP_WALK       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_BAD_NODE = 2'd2,
        STS_SENTINEL = 2'd3
    } t_status;

    // Channel payloads
    typedef struct packed {
        t_op                      op;
        logic [SLOT_W-1:0]        node;
        logic signed [VAL_W-1:0]  value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic                     has_value;
        logic signed [VAL_W-1:0]  value_res;
        logic                     last;
    } t_out;

    // Datapath address and link-data sources
    typedef enum logic [3:0] {
        AS_HEAD = 4'd0,
        AS_TAIL = 4'd1,
        AS_NODE = 4'd2,
        AS_REF  = 4'd3,
        AS_P    = 4'd4,
        AS_SLOT = 4'd5,
        AS_RT   = 4'd6,
        AS_RDL  = 4'd7,
        AS_RDR  = 4'd8
    } t_asel;

    typedef enum logic [1:0] {
        EM_NONE   = 2'd0,
        EM_STATUS = 2'd1,
        EM_INSERT = 2'd2,
        EM_WALK   = 2'd3
    } t_emit;

    typedef enum logic [2:0] {
        SQ_NEXT    = 3'd0,
        SQ_JUMP    = 3'd1,
        SQ_WAIT    = 3'd2,
        SQ_IF_TAIL = 3'd3,
        SQ_LOOP    = 3'd4
    } t_seq;

    // Microprogram addresses
    typedef logic [3:0] t_step;

    localparam t_step S_INIT    = 4'd0;
    localparam t_step S_IDLE    = 4'd1;
    localparam t_step S_REPLY   = 4'd2;
    localparam t_step S_W_HEAD  = 4'd3;
    localparam t_step S_W_FIRST = 4'd4;
    localparam t_step S_W_READ  = 4'd5;
    localparam t_step S_W_EMIT  = 4'd6;
    localparam t_step S_D_READ  = 4'd7;
    localparam t_step S_D_LINK  = 4'd8;
    localparam t_step S_IB_READ = 4'd9;
    localparam t_step S_IB_REF  = 4'd10;
    localparam t_step S_IA_READ = 4'd11;
    localparam t_step S_IA_FILL = 4'd12;
    localparam t_step S_IA_LINK = 4'd13;

    // One control word per step
    typedef struct packed {
        logic   l_re;
        t_asel  l_raddr;
        logic   r_re;
        t_asel  r_raddr;
        logic   v_re;
        logic   v_we;
        logic   l_we;
        t_asel  l_waddr;
        t_asel  l_wdata;
        logic   r_we;
        t_asel  r_waddr;
        t_asel  r_wdata;
        logic   ld_ref;
        logic   ld_p;
        logic   ld_rt;
        logic   clr_cnt;
        logic   inc_cnt;
        logic   live_set;
        logic   live_clr;
        logic   nf_inc;
        t_emit  emit;
        t_seq   seq;
        t_step  target;
    } t_uword;

    // Datapath status toward the sequencer
    typedef struct packed {
        logic   accept;
        t_op    op;
        logic   ok;
        logic   rd_tail;
        logic   more;
        logic   go;
    } t_flags;

    // Control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '0;
        unique case (s)
            S_INIT: begin
                w.l_we    = 1'b1;
                w.l_waddr = AS_TAIL;
                w.l_wdata = AS_HEAD;
                w.r_we    = 1'b1;
                w.r_waddr = AS_HEAD;
                w.r_wdata = AS_TAIL;
                w.seq     = SQ_JUMP;
                w.target  = S_IDLE;
            end
            S_IDLE: begin
                w.seq = SQ_WAIT;
            end
            S_REPLY: begin
                w.emit   = EM_STATUS;
                w.seq    = SQ_JUMP;
                w.target = S_IDLE;
            end
            S_W_HEAD: begin
                w.r_re    = 1'b1;
                w.r_raddr = AS_HEAD;
                w.seq     = SQ_NEXT;
            end
            S_W_FIRST: begin
                w.ld_p    = 1'b1;
                w.clr_cnt = 1'b1;
                w.seq     = SQ_IF_TAIL;
                w.target  = S_REPLY;
            end
            S_W_READ: begin
                w.r_re    = 1'b1;
                w.r_raddr = AS_P;
                w.v_re    = 1'b1;
                w.seq     = SQ_NEXT;
            end
            S_W_EMIT: begin
                w.emit    = EM_WALK;
                w.ld_p    = 1'b1;
                w.inc_cnt = 1'b1;
                w.seq     = SQ_LOOP;
                w.target  = S_W_READ;
            end
            S_D_READ: begin
                w.l_re    = 1'b1;
                w.l_raddr = AS_NODE;
                w.r_re    = 1'b1;
                w.r_raddr = AS_NODE;
                w.seq     = SQ_NEXT;
            end
            S_D_LINK: begin
                w.l_we     = 1'b1;
                w.l_waddr  = AS_RDR;
                w.l_wdata  = AS_RDL;
                w.r_we     = 1'b1;
                w.r_waddr  = AS_RDL;
                w.r_wdata  = AS_RDR;
                w.live_clr = 1'b1;
                w.emit     = EM_STATUS;
                w.seq      = SQ_JUMP;
                w.target   = S_IDLE;
            end
            S_IB_READ: begin
                w.l_re    = 1'b1;
                w.l_raddr = AS_NODE;
                w.seq     = SQ_NEXT;
            end
            S_IB_REF: begin
                w.ld_ref  = 1'b1;
                w.r_re    = 1'b1;
                w.r_raddr = AS_RDL;
                w.seq     = SQ_JUMP;
                w.target  = S_IA_FILL;
            end
            S_IA_READ: begin
                w.r_re    = 1'b1;
                w.r_raddr = AS_REF;
                w.seq     = SQ_NEXT;
            end
            S_IA_FILL: begin
                w.v_we    = 1'b1;
                w.l_we    = 1'b1;
                w.l_waddr = AS_SLOT;
                w.l_wdata = AS_REF;
                w.r_we    = 1'b1;
                w.r_waddr = AS_SLOT;
                w.r_wdata = AS_RDR;
                w.ld_rt   = 1'b1;
                w.seq     = SQ_NEXT;
            end
            S_IA_LINK: begin
                w.l_we     = 1'b1;
                w.l_waddr  = AS_RT;
                w.l_wdata  = AS_SLOT;
                w.r_we     = 1'b1;
                w.r_waddr  = AS_REF;
                w.r_wdata  = AS_SLOT;
                w.live_set = 1'b1;
                w.nf_inc   = 1'b1;
                w.emit     = EM_INSERT;
                w.seq      = SQ_JUMP;
                w.target   = S_IDLE;
            end
            default: begin
                w.seq    = SQ_JUMP;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/static_doubly_linked_list_core.sv */
`timescale 1ns / 1ps
// Channel   Valid        Ready        Payload       Transfer
// input     i_in_valid   o_in_ready   i_in_data     op, node, value
// output    o_out_valid  i_out_ready  o_out_data    status, slot, has_value, value_res, last
//
// One item at a time, run by a microprogram over the link and value stores.
// Each item runs as a chain of microprogram steps, accept included, because the
// link stores are read through registered ports.
// Reset: a setup step after reset writes the sentinel links; input is held off.
// A full output register stalls only the emitting step; once that step has loaded
// its result, the next input is taken while the result waits there.

module static_doubly_linked_list_core import sdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_uword uw;
    t_flags flags;

    sdll_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    sdll_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uw),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = (uw.seq == SQ_WAIT);

    // Dispatch always leaves the wait step
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("sequencer stayed in wait step after a transfer");

    // A walk never reports a sentinel
    a_walk_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.has_value)
            |-> (o_out_data.slot != HEAD && o_out_data.slot != TAIL))
        else $error("walk emitted a sentinel slot");

    // Errors are single bare results
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STS_OK)
            |-> (o_out_data.last && !o_out_data.has_value && o_out_data.slot == HEAD))
        else $error("error result carries data");

endmodule

/* rtl/sdll_sequencer.sv */
`timescale 1ns / 1ps

module sdll_sequencer import sdll_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_step  disp;
    t_uword uw;

    // Fetch the control word for the current step
    assign uw      = ucode(r_step);
    assign o_uword = uw;

    // Pick the entry step for an accepted item
    always_comb begin
        if (i_flags.op == OP_WALK) begin
            disp = S_W_HEAD;
        end else if (!i_flags.ok) begin
            disp = S_REPLY;
        end else if (i_flags.op == OP_DELETE) begin
            disp = S_D_READ;
        end else if (i_flags.op == OP_INS_BEFORE) begin
            disp = S_IB_READ;
        end else begin
            disp = S_IA_READ;
        end
    end

    // Advance, jump or hold
    always_comb begin
        n_step = r_step;
        if (i_flags.go) begin
            unique case (uw.seq)
                SQ_NEXT:    n_step = r_step + 4'd1;
                SQ_JUMP:    n_step = uw.target;
                SQ_WAIT:    n_step = i_flags.accept ? disp : r_step;
                SQ_IF_TAIL: n_step = i_flags.rd_tail ? uw.target : r_step + 4'd1;
                SQ_LOOP:    n_step = i_flags.more ? uw.target : S_IDLE;
                default:    n_step = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_INIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/sdll_datapath.sv */
`timescale 1ns / 1ps

module sdll_datapath import sdll_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_uword i_uword,
    input  logic   i_in_valid,
    input  t_in    i_in_data,
    input  logic   i_out_ready,
    output t_flags o_flags,
    output logic   o_out_valid,
    output t_out   o_out_data
);

    // Link and value stores
    logic [SLOT_W-1:0] r_left_links  [NODES];
    logic [SLOT_W-1:0] r_right_links [NODES];
    logic [VAL_W-1:0]  r_node_values [NODES];

    logic [SLOT_W-1:0] r_rdl;
    logic [SLOT_W-1:0] r_rdr;
    logic [VAL_W-1:0]  r_vrd;

    // Working registers
    logic [SLOT_W-1:0] r_node;
    logic [VAL_W-1:0]  r_value;
    t_status           r_status;
    logic [SLOT_W-1:0] r_ref;
    logic [SLOT_W-1:0] r_p;
    logic [SLOT_W-1:0] r_rt;
    logic [SLOT_W-1:0] r_cnt;
    logic [SLOT_W:0]   r_nf;
    logic [NODES-1:0]  r_live;
    logic              r_out_valid;
    t_out              r_out;

    logic              accept;
    logic              go;
    logic              fin;
    t_status           n_status;
    t_out              n_out;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] l_raddr;
    logic [SLOT_W-1:0] r_raddr;
    logic [SLOT_W-1:0] l_waddr;
    logic [SLOT_W-1:0] l_wdata;
    logic [SLOT_W-1:0] r_waddr;
    logic [SLOT_W-1:0] r_wdata;

    function automatic logic [SLOT_W-1:0] pick(
        input t_asel             a,
        input logic [SLOT_W-1:0] node,
        input logic [SLOT_W-1:0] refn,
        input logic [SLOT_W-1:0] p,
        input logic [SLOT_W-1:0] s,
        input logic [SLOT_W-1:0] rt,
        input logic [SLOT_W-1:0] rdl,
        input logic [SLOT_W-1:0] rdr
    );
        logic [SLOT_W-1:0] v;
        unique case (a)
            AS_HEAD: v = HEAD;
            AS_TAIL: v = TAIL;
            AS_NODE: v = node;
            AS_REF:  v = refn;
            AS_P:    v = p;
            AS_SLOT: v = s;
            AS_RT:   v = rt;
            AS_RDL:  v = rdl;
            AS_RDR:  v = rdr;
            default: v = HEAD;
        endcase
        return v;
    endfunction

    assign slot   = r_nf[SLOT_W-1:0];
    assign accept = (i_uword.seq == SQ_WAIT) && i_in_valid;
    // Stall a step that emits while the output register is still full
    assign go     = !((i_uword.emit != EM_NONE) && r_out_valid && !i_out_ready);

    // Walk ends at the tail or at the element limit
    assign fin = (r_rdr == TAIL)
              || (({1'b0, r_cnt} + (SLOT_W+1)'(1)) >= (SLOT_W+1)'(NODES - 2))
              || ({1'b0, r_rdr} >= (SLOT_W+1)'(NODES));

    // Check an incoming item
    always_comb begin
        if (i_in_data.op == OP_WALK) begin
            n_status = STS_OK;
        end else if (({1'b0, i_in_data.node} >= (SLOT_W+1)'(NODES))
                     || !r_live[i_in_data.node]) begin
            n_status = STS_BAD_NODE;
        end else if (i_in_data.op == OP_DELETE) begin
            n_status = (i_in_data.node == HEAD || i_in_data.node == TAIL)
                     ? STS_SENTINEL : STS_OK;
        end else if ((i_in_data.op == OP_INS_AFTER && i_in_data.node == TAIL)
                     || (i_in_data.op == OP_INS_BEFORE && i_in_data.node == HEAD)) begin
            n_status = STS_SENTINEL;
        end else if (r_nf >= (SLOT_W+1)'(NODES)) begin
            n_status = STS_FULL;
        end else begin
            n_status = STS_OK;
        end
    end

    // Route addresses and link data
    assign l_raddr = pick(i_uword.l_raddr, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);
    assign r_raddr = pick(i_uword.r_raddr, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);
    assign l_waddr = pick(i_uword.l_waddr, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);
    assign l_wdata = pick(i_uword.l_wdata, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);
    assign r_waddr = pick(i_uword.r_waddr, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);
    assign r_wdata = pick(i_uword.r_wdata, r_node, r_ref, r_p, slot, r_rt, r_rdl, r_rdr);

    // Left link store
    always_ff @(posedge i_clk) begin
        if (go && i_uword.l_we) begin
            r_left_links[l_waddr] <= l_wdata;
        end
        if (i_uword.l_re) begin
            r_rdl <= r_left_links[l_raddr];
        end
    end

    // Right link store
    always_ff @(posedge i_clk) begin
        if (go && i_uword.r_we) begin
            r_right_links[r_waddr] <= r_wdata;
        end
        if (i_uword.r_re) begin
            r_rdr <= r_right_links[r_raddr];
        end
    end

    // Value store
    always_ff @(posedge i_clk) begin
        if (go && i_uword.v_we) begin
            r_node_values[slot] <= r_value;
        end
        if (i_uword.v_re) begin
            r_vrd <= r_node_values[r_p];
        end
    end

    // Capture the item and working pointers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_node   <= i_in_data.node;
            r_value  <= i_in_data.value;
            r_status <= n_status;
            r_ref    <= i_in_data.node;
        end else if (go && i_uword.ld_ref) begin
            r_ref <= r_rdl;
        end
        if (go && i_uword.ld_p) begin
            r_p <= r_rdr;
        end
        if (go && i_uword.ld_rt) begin
            r_rt <= r_rdr;
        end
        if (go && i_uword.clr_cnt) begin
            r_cnt <= '0;
        end else if (go && i_uword.inc_cnt) begin
            r_cnt <= r_cnt + SLOT_W'(1);
        end
    end

    // Live marks and free pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= NODES'(2'b11);
            r_nf   <= FIRST_FREE;
        end else if (go) begin
            if (i_uword.live_set) begin
                r_live[slot] <= 1'b1;
            end
            if (i_uword.live_clr) begin
                r_live[r_node] <= 1'b0;
            end
            if (i_uword.nf_inc) begin
                r_nf <= r_nf + (SLOT_W+1)'(1);
            end
        end
    end

    // Build the result
    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        case (i_uword.emit)
            EM_STATUS: begin
                n_out.status = r_status;
            end
            EM_INSERT: begin
                n_out.status = STS_OK;
                n_out.slot   = slot;
            end
            EM_WALK: begin
                n_out.status    = STS_OK;
                n_out.slot      = r_p;
                n_out.has_value = 1'b1;
                n_out.value_res = r_vrd;
                n_out.last      = fin;
            end
            default: begin
                n_out.status = STS_OK;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && i_uword.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_uword.emit != EM_NONE) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_flags.accept  = accept;
    assign o_flags.op      = i_in_data.op;
    assign o_flags.ok      = (n_status == STS_OK);
    assign o_flags.rd_tail = (r_rdr == TAIL);
    assign o_flags.more    = !fin;
    assign o_flags.go      = go;

endmodule

/* verif/sdll_checker.sv */
`timescale 1ns / 1ps

module sdll_checker import sdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow copy of the list store
    logic signed [VAL_W-1:0] node_val [NODES];
    logic [SLOT_W-1:0]       left_of  [NODES];
    logic [SLOT_W-1:0]       right_of [NODES];
    logic                    slot_live[NODES];
    logic [SLOT_W:0]         next_slot;

    t_out expected_q[$];
    int   mismatches;
    int   outstanding;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("sdll_checker: %0t ns: %s", $time, what);
    endtask

    // Restore sentinels and slot counter
    task automatic clear_list();
        for (int k = 0; k < NODES; k++) begin
            node_val[k]  = '0;
            left_of[k]   = '0;
            right_of[k]  = '0;
            slot_live[k] = 1'b0;
        end
        right_of[HEAD]  = TAIL;
        left_of[TAIL]   = HEAD;
        slot_live[HEAD] = 1'b1;
        slot_live[TAIL] = 1'b1;
        next_slot       = FIRST_FREE;
        expected_q.delete();
    endtask

    // Build a result that carries only a status
    function automatic t_out status_only(input t_status sts);
        t_out r;
        r           = '0;
        r.status    = sts;
        r.last      = 1'b1;
        return r;
    endfunction

    // Apply one transfer to the shadow list and queue its results
    task automatic predict_item(input t_in it);
        t_out              r;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] ref_slot;
        logic [SLOT_W-1:0] rt;
        logic [SLOT_W-1:0] lf;
        logic [SLOT_W-1:0] s;
        int                n;

        if (it.op == OP_WALK) begin
            n = 0;
            p = right_of[HEAD];
            while (p != TAIL && n < NODES - 2) begin
                nx          = right_of[p];
                r           = '0;
                r.status    = STS_OK;
                r.slot      = p;
                r.has_value = 1'b1;
                r.value_res = node_val[p];
                r.last      = (nx == TAIL) || (n + 1 >= NODES - 2);
                expected_q.push_back(r);
                n++;
                p = nx;
            end
            // Empty list still answers once
            if (n == 0) begin
                expected_q.push_back(status_only(STS_OK));
            end
            return;
        end

        if (int'(it.node) >= NODES || !slot_live[it.node]) begin
            expected_q.push_back(status_only(STS_BAD_NODE));
            return;
        end

        if (it.op == OP_DELETE) begin
            if (it.node == HEAD || it.node == TAIL) begin
                expected_q.push_back(status_only(STS_SENTINEL));
                return;
            end
            lf                  = left_of[it.node];
            rt                  = right_of[it.node];
            left_of[rt]         = lf;
            right_of[lf]        = rt;
            slot_live[it.node]  = 1'b0;
            expected_q.push_back(status_only(STS_OK));
            return;
        end

        if ((it.op == OP_INS_AFTER && it.node == TAIL) ||
            (it.op == OP_INS_BEFORE && it.node == HEAD)) begin
            expected_q.push_back(status_only(STS_SENTINEL));
            return;
        end
        if (int'(next_slot) >= NODES) begin
            expected_q.push_back(status_only(STS_FULL));
            return;
        end

        // Splice the new slot in right of the reference node
        ref_slot           = (it.op == OP_INS_AFTER) ? it.node : left_of[it.node];
        s                  = next_slot[SLOT_W-1:0];
        rt                 = right_of[ref_slot];
        node_val[s]        = it.value;
        left_of[s]         = ref_slot;
        right_of[s]        = rt;
        left_of[rt]        = s;
        right_of[ref_slot] = s;
        slot_live[s]       = 1'b1;
        next_slot          = next_slot + (SLOT_W+1)'(1);
        r                  = status_only(STS_OK);
        r.slot             = s;
        expected_q.push_back(r);
    endtask

    // Compare one result with the oldest expectation
    task automatic check_result(input t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, status %0d slot %0d",
                                      got.status, got.slot));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
        if (got.slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
        end
        if (got.has_value !== want.has_value) begin
            report_mismatch($sformatf("has_value %0b, expected %0b",
                                      got.has_value, want.has_value));
        end
        if (got.value_res !== want.value_res) begin
            report_mismatch($sformatf("value_res %0d, expected %0d",
                                      got.value_res, want.value_res));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        end
    endtask

    // Watch both channels; retire results before taking a new transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_list();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_in_data);
            end
        end
        outstanding = expected_q.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sdll_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 230;
    localparam int QUIET_TAIL     = 40;
    localparam int HOLD_AT_ITEM   = 60;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_NS     = 10_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int   fail_count;
    int   pending;

    // Stimulus bookkeeping: which slots are in the list, how many are taken
    logic slot_live[NODES];
    int   slots_used;
    int   items_sent    = 0;
    logic quiet         = 1'b0;
    logic pressure_done = 1'b0;

    always #5 clk = ~clk;

    static_doubly_linked_list_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sdll_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in make_item(input t_op op, input int node, input logic [31:0] value);
        t_in it;
        it.op    = op;
        it.node  = SLOT_W'(node);
        it.value = value;
        return it;
    endfunction

    // Pick a random slot that is in the list, skipping up to two slots
    function automatic int pick_live(input int skip_a, input int skip_b);
        int cand[$];
        for (int k = 0; k < NODES; k++) begin
            if (slot_live[k] && k != skip_a && k != skip_b) begin
                cand.push_back(k);
            end
        end
        if (cand.size() == 0) begin
            return -1;
        end
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Follow membership so random references mostly hit live nodes
    function automatic void track_item(input t_in it);
        if (it.op == OP_WALK || !slot_live[it.node]) begin
            return;
        end
        if (it.op == OP_DELETE) begin
            if (it.node != HEAD && it.node != TAIL) begin
                slot_live[it.node] = 1'b0;
            end
        end else if (!((it.op == OP_INS_AFTER && it.node == TAIL) ||
                       (it.op == OP_INS_BEFORE && it.node == HEAD)) &&
                     slots_used < NODES) begin
            slot_live[slots_used] = 1'b1;
            slots_used++;
        end
    endfunction

    // Mostly well-formed inserts and deletes, some walks, some noise
    function automatic t_in random_item();
        t_in it;
        int  r;
        int  pick;
        r        = $urandom_range(0, 99);
        it.value = $urandom;
        it.node  = SLOT_W'($urandom_range(0, NODES - 1));
        pick     = -1;
        if (r < 40) begin
            it.op = ($urandom_range(0, 1) == 0) ? OP_INS_AFTER : OP_INS_BEFORE;
            if ($urandom_range(0, 9) != 0) begin
                pick = (it.op == OP_INS_AFTER) ? pick_live(TAIL, TAIL) : pick_live(HEAD, HEAD);
            end
        end else if (r < 65) begin
            it.op = OP_DELETE;
            if ($urandom_range(0, 9) != 0) begin
                pick = pick_live(HEAD, TAIL);
            end
        end else if (r < 75) begin
            it.op = OP_WALK;
        end else begin
            it.op = t_op'($urandom_range(0, 3));
        end
        if (pick >= 0) begin
            it.node = SLOT_W'(pick);
        end
        return it;
    endfunction

    // Drop valid for a burst of cycles
    task automatic sender_gap(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Present one transfer and hold it until accepted
    task automatic issue(input t_in item);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            sender_gap($urandom_range(1, 7));
        end
        track_item(item);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stimulus and verdict
    initial begin
        t_in item;
        for (int k = 0; k < NODES; k++) begin
            slot_live[k] = 1'b0;
        end
        slot_live[HEAD] = 1'b1;
        slot_live[TAIL] = 1'b1;
        slots_used      = FIRST_FREE;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: sentinels, bad nodes, value extremes, references to a deleted slot
        issue(make_item(OP_WALK, 63, 32'hFFFF_FFFF));
        issue(make_item(OP_DELETE, HEAD, 32'h0));
        issue(make_item(OP_DELETE, TAIL, 32'h0));
        issue(make_item(OP_INS_AFTER, TAIL, 32'h1111_1111));
        issue(make_item(OP_INS_BEFORE, HEAD, 32'h2222_2222));
        issue(make_item(OP_INS_AFTER, 2, 32'h3333_3333));
        issue(make_item(OP_DELETE, 63, 32'h0));
        issue(make_item(OP_INS_AFTER, HEAD, 32'h7FFF_FFFF));
        issue(make_item(OP_INS_BEFORE, TAIL, 32'h8000_0000));
        issue(make_item(OP_INS_BEFORE, 2, 32'hFFFF_FFFF));
        issue(make_item(OP_INS_AFTER, 2, 32'h0000_0000));
        issue(make_item(OP_WALK, 0, 32'h0));
        issue(make_item(OP_DELETE, 2, 32'h0));
        issue(make_item(OP_DELETE, 2, 32'h0));
        issue(make_item(OP_INS_AFTER, 2, 32'h4444_4444));
        issue(make_item(OP_INS_BEFORE, 2, 32'h5555_5555));
        issue(make_item(OP_WALK, 42, 32'h0));
        issue(make_item(OP_DELETE, 4, 32'h0));
        issue(make_item(OP_DELETE, 5, 32'h0));
        issue(make_item(OP_DELETE, 3, 32'h0));
        issue(make_item(OP_WALK, 0, 32'h0));
        issue(make_item(OP_INS_BEFORE, TAIL, 32'h0000_3039));
        issue(make_item(OP_INS_AFTER, HEAD, 32'hA5A5_5A5A));
        issue(make_item(OP_WALK, 0, 32'h0));

        // Random part; the tail of it runs without idling
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k >= RANDOM_ITEMS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            item = random_item();
            issue(item);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, free running at the end
    initial begin
        int stall;
        @(negedge clk);
        forever begin
            if (!pressure_done && items_sent >= HOLD_AT_ITEM) begin
                pressure_done = 1'b1;
                out_ready <= 1'b0;
                stall = HOLD_CYCLES;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 7);
            end else begin
                out_ready <= 1'b1;
                stall = $urandom_range(1, 20);
            end
            repeat (stall) @(negedge clk);
        end
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
